>>> hdl/tcc_pkg.sv
// Package: geometry constants, shared types and the victim LFSR step.
package tcc_pkg;

	localparam int ADDR_W     = 32;
	localparam int OFF_W      = 6;
	localparam int BLK_W      = ADDR_W - OFF_W;
	localparam int L1_IDX_W   = 7;
	localparam int L1_SETS    = 1 << L1_IDX_W;
	localparam int L1_TAG_W   = BLK_W - L1_IDX_W;
	localparam int L1_WAYS    = 8;
	localparam int L1_WAY_W   = 3;
	localparam int L2_IDX_W   = 12;
	localparam int L2_SETS    = 1 << L2_IDX_W;
	localparam int L2_TAG_W   = BLK_W - L2_IDX_W;
	localparam int L2_WAYS    = 16;
	localparam int L2_WAY_W   = 4;
	localparam int SEED_W     = 16;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [0:0] REG_REPLACE_SEED = 1'b0;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic accept;
		logic look;
		logic clear;
		logic out_from_look;
		logic out_from_hold;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
	} sts_t;

	typedef struct packed {
		logic                l1_hit;
		logic                l1_alloc;
		logic [L1_WAY_W-1:0] l1_way;
		logic                l2_used;
		logic                l2_hit;
		logic [L2_WAY_W-1:0] l2_way;
		logic                dram_fill;
		logic [BLK_W-1:0]    fill_block;
		logic                dram_writeback;
		logic [BLK_W-1:0]    writeback_block;
	} res_t;

	typedef logic [L1_WAYS-1:0][L1_TAG_W-1:0] l1_row_t;
	typedef logic [L2_WAYS-1:0][L2_TAG_W-1:0] l2_row_t;

	typedef struct packed {
		logic [L2_WAYS-1:0] dirty;
		logic [L2_WAYS-1:0] valid;
	} l2_meta_t;

	// Fibonacci LFSR, taps 16,14,13,11
	function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] v);
		logic fb;
		fb = v[0] ^ v[2] ^ v[3] ^ v[5];
		return {fb, v[SEED_W-1:1]};
	endfunction

endpackage

>>> hdl/two_level_cache_tag_controller.sv
// Top level: two-level cache tag controller with APB seed register.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  in       | in_valid / in_stall   | kind, address
//  out      | out_valid / out_stall | l1_hit .. writeback_block
//  cfg      | psel/penable/pready   | paddr, pwrite, pwdata, prdata
//
// The accept cycle issues the registered reads of the L1 and L2 set rows; the
// next cycle compares tags, picks victims and writes back.
// A finished result waits in a hold register while the output is stalled.
// After reset a clearing pass over all 4096 L2 sets zeroes the L1 valid rows and the
// L2 valid/dirty rows; in_stall stays high during it. Seed writes are taken at any time.
module two_level_cache_tag_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic [tcc_pkg::ADDR_W-1:0]    address,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          l1_hit,
	output logic                          l1_alloc,
	output logic [tcc_pkg::L1_WAY_W-1:0]  l1_way,
	output logic                          l2_used,
	output logic                          l2_hit,
	output logic [tcc_pkg::L2_WAY_W-1:0]  l2_way,
	output logic                          dram_fill,
	output logic [tcc_pkg::BLK_W-1:0]     fill_block,
	output logic                          dram_writeback,
	output logic [tcc_pkg::BLK_W-1:0]     writeback_block,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tcc_pkg::PADDR_W-1:0]   paddr,
	input  logic [tcc_pkg::PDATA_W-1:0]   pwdata,
	output logic [tcc_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import tcc_pkg::*;

	cmd_t              cmd;
	sts_t              sts;
	res_t              res;
	logic              cfg_we;
	logic              reg_sel;
	logic [SEED_W-1:0] seed;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[PADDR_W-1] == REG_REPLACE_SEED);
	assign cfg_we  = psel && penable && pwrite && pready && reg_sel;
	assign prdata  = reg_sel ? {{(PDATA_W-SEED_W){1'b0}}, seed} : '0;

	tcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tcc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.kind      (kind),
		.address   (address),
		.cfg_we    (cfg_we),
		.cfg_wdata (pwdata[SEED_W-1:0]),
		.seed      (seed),
		.res_out   (res)
	);

	assign l1_hit          = res.l1_hit;
	assign l1_alloc        = res.l1_alloc;
	assign l1_way          = res.l1_way;
	assign l2_used         = res.l2_used;
	assign l2_hit          = res.l2_hit;
	assign l2_way          = res.l2_way;
	assign dram_fill       = res.dram_fill;
	assign fill_block      = res.fill_block;
	assign dram_writeback  = res.dram_writeback;
	assign writeback_block = res.writeback_block;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted during lookup");

	a_l2_unused_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !l2_used |-> !dram_fill && !dram_writeback && !l2_hit)
		else $error("L2 activity without L2 lookup");

	a_wb_needs_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dram_writeback |-> dram_fill && !l2_hit)
		else $error("writeback without miss fill");

	a_alloc_is_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && l1_alloc |-> !l1_hit && l2_used)
		else $error("L1 fill on hit or without L2 lookup");
`endif

endmodule

>>> hdl/tcc_ctrl.sv
// Controller: sequences clear pass, accept, lookup and result handoff.
module tcc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  tcc_pkg::sts_t sts,
	output tcc_pkg::cmd_t cmd
);
	import tcc_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   out_load;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_load  = cmd.out_from_look || cmd.out_from_hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
				if (in_valid)
					state_d = ST_LOOK;
			end
			ST_LOOK: begin
				cmd.look = 1'b1;
				if (out_free) begin
					cmd.out_from_look = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					cmd.out_from_hold = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

endmodule

>>> hdl/tcc_dp.sv
// Datapath: tag memories, valid/dirty state, victim LFSR and result registers.
module tcc_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tcc_pkg::cmd_t                cmd,
	output tcc_pkg::sts_t                sts,
	input  logic                         kind,
	input  logic [tcc_pkg::ADDR_W-1:0]   address,
	input  logic                         cfg_we,
	input  logic [tcc_pkg::SEED_W-1:0]   cfg_wdata,
	output logic [tcc_pkg::SEED_W-1:0]   seed,
	output tcc_pkg::res_t                res_out
);
	import tcc_pkg::*;

	logic                kind_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [SEED_W-1:0]   seed_q;
	logic [SEED_W-1:0]   lfsr_q;
	logic [L2_IDX_W-1:0] clr_q;
	res_t                res, res_q, out_q;

	l1_row_t             l1_mem [L1_SETS];
	logic [L1_WAYS-1:0]  l1_vmem [L1_SETS];
	l2_row_t             l2_mem [L2_SETS];
	l2_meta_t            meta_mem [L2_SETS];

	l1_row_t             l1_row_s1;
	logic [L1_WAYS-1:0]  l1_v_s1;
	l2_row_t             l2_row_s1;
	l2_meta_t            meta_s1;

	logic [L1_IDX_W-1:0] set1, rd_set1;
	logic [L1_TAG_W-1:0] tag1;
	logic [L2_IDX_W-1:0] set2, rd_set2;
	logic [L2_TAG_W-1:0] tag2;
	logic [BLK_W-1:0]    blk;

	logic [L1_WAYS-1:0]  v1, hit1;
	logic [L1_WAY_W-1:0] hw1, inv1, vic1;
	logic                any_hit1, miss_rd1;
	logic [L2_WAYS-1:0]  hit2;
	logic [L2_WAY_W-1:0] hw2, inv2, vic2, way2;
	logic                any_hit2, used2, miss2;
	logic [SEED_W-1:0]   lfsr1, lfsr_a, lfsr2, lfsr_fin;
	l1_row_t             l1_new;
	logic [L1_WAYS-1:0]  l1_vnew;
	l2_row_t             l2_new;
	l2_meta_t            meta_new;
	logic                l1_we, l2_we, meta_we;
	logic                l1_vwe;
	logic [L1_IDX_W-1:0] l1_vwa;
	logic [L1_WAYS-1:0]  l1_vwd;
	logic [L2_IDX_W-1:0] meta_wa;
	l2_meta_t            meta_wd;

	assign rd_set1 = address[OFF_W +: L1_IDX_W];
	assign rd_set2 = address[OFF_W +: L2_IDX_W];
	assign set1    = addr_q[OFF_W +: L1_IDX_W];
	assign tag1    = addr_q[ADDR_W-1 -: L1_TAG_W];
	assign set2    = addr_q[OFF_W +: L2_IDX_W];
	assign tag2    = addr_q[ADDR_W-1 -: L2_TAG_W];
	assign blk     = addr_q[ADDR_W-1:OFF_W];

	assign sts.clear_last = &clr_q;
	assign seed    = seed_q;
	assign res_out = out_q;

	// L1 lookup and victim
	always_comb begin
		v1   = l1_v_s1;
		hw1  = '0;
		inv1 = '0;
		for (int w = 0; w < L1_WAYS; w++)
			hit1[w] = v1[w] && (l1_row_s1[w] == tag1);
		for (int w = L1_WAYS - 1; w >= 0; w--) begin
			if (hit1[w])
				hw1 = L1_WAY_W'(w);
			if (!v1[w])
				inv1 = L1_WAY_W'(w);
		end
		any_hit1 = |hit1;
		miss_rd1 = !kind_q && !any_hit1;
		lfsr1    = lfsr_step(lfsr_q);
		vic1     = (&v1) ? lfsr1[L1_WAY_W-1:0] : inv1;
		lfsr_a   = (miss_rd1 && (&v1)) ? lfsr1 : lfsr_q;
		l1_new   = l1_row_s1;
		l1_new[vic1] = tag1;
		l1_vnew  = v1;
		l1_vnew[vic1] = 1'b1;
	end

	// L2 lookup, victim and metadata update
	always_comb begin
		hw2  = '0;
		inv2 = '0;
		for (int w = 0; w < L2_WAYS; w++)
			hit2[w] = meta_s1.valid[w] && (l2_row_s1[w] == tag2);
		for (int w = L2_WAYS - 1; w >= 0; w--) begin
			if (hit2[w])
				hw2 = L2_WAY_W'(w);
			if (!meta_s1.valid[w])
				inv2 = L2_WAY_W'(w);
		end
		any_hit2 = |hit2;
		used2    = kind_q || miss_rd1;
		miss2    = used2 && !any_hit2;
		lfsr2    = lfsr_step(lfsr_a);
		vic2     = (&meta_s1.valid) ? lfsr2[L2_WAY_W-1:0] : inv2;
		lfsr_fin = (miss2 && (&meta_s1.valid)) ? lfsr2 : lfsr_a;
		way2     = any_hit2 ? hw2 : vic2;
		l2_new   = l2_row_s1;
		l2_new[way2] = tag2;
		meta_new = meta_s1;
		meta_new.valid[way2] = 1'b1;
		meta_new.dirty[way2] = any_hit2 ? (meta_s1.dirty[way2] | kind_q) : kind_q;
	end

	always_comb begin
		res = '0;
		res.l1_hit   = any_hit1;
		res.l1_alloc = miss_rd1;
		res.l1_way   = any_hit1 ? hw1 : (miss_rd1 ? vic1 : '0);
		if (used2) begin
			res.l2_used   = 1'b1;
			res.l2_hit    = any_hit2;
			res.l2_way    = way2;
			res.dram_fill = miss2;
			if (miss2)
				res.fill_block = blk;
			if (miss2 && meta_s1.valid[vic2] && meta_s1.dirty[vic2]) begin
				res.dram_writeback  = 1'b1;
				res.writeback_block = {l2_row_s1[vic2], set2};
			end
		end
	end

	assign l1_we   = cmd.look && miss_rd1;
	assign l2_we   = cmd.look && used2;
	assign meta_we = cmd.clear || l2_we;
	assign meta_wa = cmd.clear ? clr_q : set2;
	assign meta_wd = cmd.clear ? '0 : meta_new;
	assign l1_vwe  = cmd.clear || l1_we;
	assign l1_vwa  = cmd.clear ? clr_q[L1_IDX_W-1:0] : set1;
	assign l1_vwd  = cmd.clear ? '0 : l1_vnew;

	always_ff @(posedge clk) begin
		l1_row_s1 <= l1_mem[rd_set1];
		l1_v_s1   <= l1_vmem[rd_set1];
		l2_row_s1 <= l2_mem[rd_set2];
		meta_s1   <= meta_mem[rd_set2];
	end

	always_ff @(posedge clk) begin
		if (l1_we)
			l1_mem[set1] <= l1_new;
		if (l1_vwe)
			l1_vmem[l1_vwa] <= l1_vwd;
		if (l2_we)
			l2_mem[set2] <= l2_new;
		if (meta_we)
			meta_mem[meta_wa] <= meta_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= SEED_W'(1);
			lfsr_q   <= SEED_W'(1);
			clr_q    <= '0;
		end else begin
			if (cmd.clear)
				clr_q <= clr_q + 1'b1;
			if (cfg_we) begin
				seed_q <= cfg_wdata;
				lfsr_q <= (cfg_wdata == '0) ? SEED_W'(1) : cfg_wdata;
			end else if (cmd.look) begin
				lfsr_q <= lfsr_fin;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q <= kind;
			addr_q <= address;
		end
		if (cmd.look)
			res_q <= res;
		if (cmd.out_from_look)
			out_q <= res;
		else if (cmd.out_from_hold)
			out_q <= res_q;
	end

endmodule
